// ===== sv/compressed_frame_layout_calc_core_assert.svh =====
// Assertion macros shared by the frame layout calculator modules.
`ifndef COMPRESSED_FRAME_LAYOUT_CALC_CORE_ASSERT_SVH
`define COMPRESSED_FRAME_LAYOUT_CALC_CORE_ASSERT_SVH

// Check that is switched off while reset is high.
`define CFLC_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that also covers the reset cycles.
`define CFLC_CHECK_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== sv/cflc_pkg.sv =====
// Shared widths and fixed constants of the frame layout calculator.
package cflc_pkg;

   localparam int DIM_W      = 14;   // width / height field
   localparam int DEPTH_W    = 5;    // bit depth field
   localparam int SIZE_W     = 28;   // luma / chroma / compressed sizes
   localparam int MV_W       = 23;
   localparam int NV12_W     = 27;
   localparam int TOTAL_W    = 29;
   localparam int ACC_W      = 29;   // internal byte-count width
   localparam int BPP_W      = 3;    // bytes per pixel, 0..4
   localparam int MAX_BPP    = 4;

   localparam int MAX_DEPTH    = 16;
   localparam int CHROMA_TILE  = 16;
   localparam int LUMA_HDR     = 32;
   localparam int CHROMA_HDR   = 8;
   localparam int ALIGN_BYTES  = 16;
   localparam int MV_SHIFT     = 6;   // 64x64 motion-vector blocks
   localparam int MV_BYTES_SH  = 8;   // 256 bytes per block

endpackage

// ===== sv/cflc_plane.sv =====
// Pipelined tile data / metadata size calculator for one image plane.
`include "compressed_frame_layout_calc_core_assert.svh"

module cflc_plane
   import cflc_pkg::*;
#(
   parameter int TILE    = 32,
   parameter int HDR     = 32,
   parameter int DIM_MAX = 8192
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [DIM_W-1:0] in_w,
   input  logic [DIM_W-1:0] in_h,
   input  logic [BPP_W-1:0] in_bpp,
   output logic             out_valid,
   output logic [ACC_W-1:0] out_data,
   output logic [ACC_W-1:0] out_meta
);

   localparam int TMAX  = (DIM_MAX + TILE - 1) / TILE;
   localparam int CW    = $clog2(TMAX + 1);
   localparam int PW    = CW + 1;
   localparam int NW    = DIM_W + 1;
   // ceil division by TILE via reciprocal; exact for numerators below 2^15
   localparam int RK    = 22;
   localparam int RM    = ((1 << RK) + TILE - 1) / TILE;
   localparam int RMW   = $clog2(RM + 1);
   localparam int PRW   = NW + RMW;
   localparam int TAREA = TILE * TILE;
   localparam int TBW   = $clog2(TAREA * MAX_BPP + 1);

   function automatic logic [CW-1:0] tile_count(input logic [DIM_W-1:0] d);
      logic [NW-1:0]  n;
      logic [PRW-1:0] p;
      n = NW'(d) + NW'(TILE - 1);
      p = PRW'(n) * PRW'(RM);
      return p[RK +: CW];
   endfunction

   // smallest power of two not below n; zero maps to one
   function automatic logic [PW-1:0] pow2_ceil(input logic [CW-1:0] n);
      logic [CW-1:0] m;
      logic [CW-1:0] s;
      m = n - CW'(1);
      s = '0;
      for (int i = 0; i < CW; i++) begin
         s[i] = |(m >> i);
      end
      if (n <= CW'(1)) begin
         return PW'(1);
      end
      return PW'(s) + PW'(1);
   endfunction

   function automatic logic [ACC_W-1:0] align16(input logic [ACC_W-1:0] x);
      logic [ACC_W-1:0] t;
      t = x + ACC_W'(ALIGN_BYTES - 1);
      return t & ~ACC_W'(ALIGN_BYTES - 1);
   endfunction

   // stage A: tile counts
   logic             va_ff;
   logic [CW-1:0]    tw_ff, th_ff;
   logic [BPP_W-1:0] bpp_a_ff;
   // stage B: tile product, metadata grid product
   logic             vb_ff;
   logic [2*CW-1:0]  tiles_ff;
   logic [2*PW-1:0]  grid_ff;
   logic [BPP_W-1:0] bpp_b_ff;
   // stage C: raw sizes
   logic             vc_ff;
   logic [ACC_W-1:0] data_raw_ff, meta_raw_ff;
   // stage D: aligned sizes
   logic             vd_ff;
   logic [ACC_W-1:0] data_ff, meta_ff;

   logic [PW-1:0]    p2w_in, p2h_in;
   logic [TBW-1:0]   tbytes_in;

   assign p2w_in    = pow2_ceil(tw_ff);
   assign p2h_in    = pow2_ceil(th_ff);
   assign tbytes_in = TBW'(TBW'(TAREA) * TBW'(bpp_b_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      tw_ff       <= tile_count(in_w);
      th_ff       <= tile_count(in_h);
      bpp_a_ff    <= in_bpp;
      tiles_ff    <= (2*CW)'(tw_ff) * (2*CW)'(th_ff);
      grid_ff     <= (2*PW)'(p2w_in) * (2*PW)'(p2h_in);
      bpp_b_ff    <= bpp_a_ff;
      data_raw_ff <= ACC_W'(tiles_ff) * ACC_W'(tbytes_in);
      meta_raw_ff <= ACC_W'(grid_ff) * ACC_W'(HDR);
      data_ff     <= align16(data_raw_ff);
      meta_ff     <= align16(meta_raw_ff);
   end

   assign out_valid = vd_ff;
   assign out_data  = data_ff;
   assign out_meta  = meta_ff;

   `CFLC_CHECK(plane_latency_a, clock, reset, out_valid == $past(in_valid, 4), "plane valid skew")
   `CFLC_CHECK(plane_meta_a, clock, reset, out_valid |-> (out_meta != '0), "empty metadata")
   `CFLC_CHECK(plane_align_a, clock, reset, out_valid |-> (out_data[3:0] == 4'd0), "data misaligned")

endmodule

// ===== sv/compressed_frame_layout_calc_core.sv =====
// Top level of the compressed reference-frame layout calculator.
// A beat taken at a clock edge (start high, busy low) passes s0, the plane stages s1..s4
// and s5..s7, and shows on the rsp_ ports with rsp_valid high for exactly one cycle.
// Throughput: one beat per cycle while busy is low; the 8-stage datapath has no stalls.
// Reset (synchronous, active high) clears all valid bits; busy is high during reset and
// for the first cycle after it, and low from then on.
`include "compressed_frame_layout_calc_core_assert.svh"

module compressed_frame_layout_calc_core
   import cflc_pkg::*;
#(
   parameter int LUMA_TILE     = 32,
   parameter int MAX_DIMENSION = 8192
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [DIM_W-1:0]     req_width,
   input  logic [DIM_W-1:0]     req_height,
   input  logic [DEPTH_W-1:0]   req_bit_depth,
   output logic                 rsp_valid,
   output logic [SIZE_W-1:0]    rsp_luma_data_bytes,
   output logic [SIZE_W-1:0]    rsp_luma_meta_end,
   output logic [SIZE_W-1:0]    rsp_chroma_data_offset,
   output logic [SIZE_W-1:0]    rsp_compressed_size,
   output logic [MV_W-1:0]      rsp_mv_size,
   output logic [NV12_W-1:0]    rsp_nv12_size,
   output logic [TOTAL_W-1:0]   rsp_total_size
);

   localparam int CHROMA_MAX = MAX_DIMENSION / 2;
   localparam int MVB_W      = DIM_W + 1 - MV_SHIFT;   // 64-pixel blocks per side
   localparam int WH_W       = 2 * DIM_W;

   // Stage map:
   //   s0      saturated geometry
   //   s1..s4  luma / chroma plane pipelines, side path for NV12 and MV sizes
   //   s5      y + ym, uv + uvm
   //   s6      chroma data offset, compressed size
   //   s7      total size, result registers

   logic accept;
   logic busy_ff;

   // s0
   logic               v0_ff;
   logic [DIM_W-1:0]   w0_ff, h0_ff;
   logic [DEPTH_W-1:0] bd0_ff;
   logic [DIM_W-1:0]   w_sat_in, h_sat_in;
   logic [DEPTH_W-1:0] bd_sat_in;

   // bytes per pixel: ceil(bits / 8)
   logic [DEPTH_W:0]   bits_l_in, bits_c_in;
   logic [BPP_W-1:0]   bpp_l_in, bpp_c_in;

   // side path
   logic [WH_W-1:0]    wh1_ff;
   logic [MVB_W-1:0]   mvw1_ff, mvh1_ff;
   logic [ACC_W-1:0]   nv12_2_ff, mv2_ff;
   logic [ACC_W-1:0]   nv12_3_ff, mv3_ff, nvmv3_ff;
   logic [ACC_W-1:0]   nv12_4_ff, mv4_ff, nvmv4_ff;

   // plane outputs, aligned with s4
   logic               luma_valid, chroma_valid;
   logic [ACC_W-1:0]   y_data, y_meta, uv_data, uv_meta;

   // s5 .. s7
   logic               v5_ff, v6_ff, v7_ff;
   logic [ACC_W-1:0]   y5_ff, uv5_ff, yym5_ff, uvs5_ff, nv12_5_ff, mv5_ff, nvmv5_ff;
   logic [ACC_W-1:0]   y6_ff, yym6_ff, cdo6_ff, comp6_ff, nv12_6_ff, mv6_ff, nvmv6_ff;
   logic [ACC_W-1:0]   y7_ff, yym7_ff, cdo7_ff, comp7_ff, nv12_7_ff, mv7_ff, tot7_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // oversized geometry and bit depth clamp to the supported maxima
   assign w_sat_in  = (req_width > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : req_width;
   assign h_sat_in  = (req_height > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : req_height;
   assign bd_sat_in = (req_bit_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                            : req_bit_depth;

   // chroma runs at twice the luma depth
   assign bits_l_in = {1'b0, bd0_ff} + (DEPTH_W+1)'(7);
   assign bits_c_in = {bd0_ff, 1'b0} + (DEPTH_W+1)'(7);
   assign bpp_l_in  = BPP_W'(bits_l_in >> 3);
   assign bpp_c_in  = BPP_W'(bits_c_in >> 3);

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v5_ff <= luma_valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         w0_ff  <= w_sat_in;
         h0_ff  <= h_sat_in;
         bd0_ff <= bd_sat_in;
      end
   end

   // NV12 and motion-vector sizes, kept in step with the plane pipelines
   always_ff @(posedge clock) begin
      wh1_ff    <= WH_W'(w0_ff) * WH_W'(h0_ff);
      mvw1_ff   <= MVB_W'(((DIM_W+1)'(w0_ff) + (DIM_W+1)'(63)) >> MV_SHIFT);
      mvh1_ff   <= MVB_W'(((DIM_W+1)'(h0_ff) + (DIM_W+1)'(63)) >> MV_SHIFT);

      nv12_2_ff <= ACC_W'(wh1_ff) + ACC_W'(wh1_ff >> 1);
      mv2_ff    <= (ACC_W'(mvw1_ff) * ACC_W'(mvh1_ff)) << MV_BYTES_SH;

      nv12_3_ff <= nv12_2_ff;
      mv3_ff    <= mv2_ff;
      nvmv3_ff  <= nv12_2_ff + mv2_ff;

      nv12_4_ff <= nv12_3_ff;
      mv4_ff    <= mv3_ff;
      nvmv4_ff  <= nvmv3_ff;
   end

   cflc_plane #(
      .TILE    (LUMA_TILE),
      .HDR     (LUMA_HDR),
      .DIM_MAX (MAX_DIMENSION)
   ) u_luma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_w      (w0_ff),
      .in_h      (h0_ff),
      .in_bpp    (bpp_l_in),
      .out_valid (luma_valid),
      .out_data  (y_data),
      .out_meta  (y_meta)
   );

   // chroma: half resolution, rounded down
   cflc_plane #(
      .TILE    (CHROMA_TILE),
      .HDR     (CHROMA_HDR),
      .DIM_MAX (CHROMA_MAX)
   ) u_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_w      (w0_ff >> 1),
      .in_h      (h0_ff >> 1),
      .in_bpp    (bpp_c_in),
      .out_valid (chroma_valid),
      .out_data  (uv_data),
      .out_meta  (uv_meta)
   );

   // running offsets: y | ym | uv | uvm
   always_ff @(posedge clock) begin
      y5_ff     <= y_data;
      uv5_ff    <= uv_data;
      yym5_ff   <= y_data + y_meta;
      uvs5_ff   <= uv_data + uv_meta;
      nv12_5_ff <= nv12_4_ff;
      mv5_ff    <= mv4_ff;
      nvmv5_ff  <= nvmv4_ff;

      y6_ff     <= y5_ff;
      yym6_ff   <= yym5_ff;
      cdo6_ff   <= yym5_ff + uv5_ff;
      comp6_ff  <= yym5_ff + uvs5_ff;
      nv12_6_ff <= nv12_5_ff;
      mv6_ff    <= mv5_ff;
      nvmv6_ff  <= nvmv5_ff;

      y7_ff     <= y6_ff;
      yym7_ff   <= yym6_ff;
      cdo7_ff   <= cdo6_ff;
      comp7_ff  <= comp6_ff;
      nv12_7_ff <= nv12_6_ff;
      mv7_ff    <= mv6_ff;
      tot7_ff   <= comp6_ff + nvmv6_ff;
   end

   assign rsp_valid              = v7_ff;
   assign rsp_luma_data_bytes    = y7_ff[SIZE_W-1:0];
   assign rsp_luma_meta_end      = yym7_ff[SIZE_W-1:0];
   assign rsp_chroma_data_offset = cdo7_ff[SIZE_W-1:0];
   assign rsp_compressed_size    = comp7_ff[SIZE_W-1:0];
   assign rsp_mv_size            = mv7_ff[MV_W-1:0];
   assign rsp_nv12_size          = nv12_7_ff[NV12_W-1:0];
   assign rsp_total_size         = tot7_ff[TOTAL_W-1:0];

   `CFLC_CHECK(rsp_latency_a, clock, reset, accept |-> ##8 v7_ff, "result beat missing")
   `CFLC_CHECK(rsp_origin_a, clock, reset, v7_ff |-> $past(accept, 8), "result beat timing")
   `CFLC_CHECK(planes_aligned_a, clock, reset, luma_valid == chroma_valid, "plane skew")
   `CFLC_CHECK(offset_order_a, clock, reset, v7_ff |-> (cdo7_ff >= yym7_ff), "offset order")
   `CFLC_CHECK_NORST(reset_state_a, clock, reset |=> (busy_ff && !v7_ff), "reset state")

endmodule
